FILE: src/rgc_pkg.sv
// Shared types, constants and decision functions of the receiver gain controller.
`default_nettype none

package rgc_pkg;

  // History depth; the median is taken over this many observation windows.
  localparam int unsigned WINDOW_DEPTH = 5;
  localparam int unsigned FILL_W       = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned MEDIAN_RANK  = WINDOW_DEPTH / 2;

  // Field widths of one observation and of the gain.
  localparam int unsigned AMP_W  = 8;
  localparam int unsigned RATE_W = 10;
  localparam int unsigned GAIN_W = 8;
  localparam int unsigned OBS_W  = 2 * AMP_W + 3 * RATE_W;

  // Counter widths.
  localparam int unsigned SETTLE_W = 4;
  localparam int unsigned RUN_W    = 8;
  localparam int unsigned LBAD_W   = 3;
  localparam int unsigned GUARD_W  = 5;

  // Timing and confirmation constants.
  localparam logic [SETTLE_W-1:0] SETTLE_TICKS     = 4'd10;
  localparam logic [SETTLE_W-1:0] FAST_SETTLE_MAX  = 4'd8;
  localparam logic [LBAD_W-1:0]   LOCK_BAD_TICKS   = 3'd6;
  localparam logic [RUN_W-1:0]    UP_CONFIRM       = 8'd5;
  localparam logic [RUN_W-1:0]    HARD_UP_CONFIRM  = 8'd3;
  localparam logic [RUN_W-1:0]    OVERLOAD_CONFIRM = 8'd2;
  localparam logic [RUN_W-1:0]    HIGH_CONFIRM     = 8'd3;
  localparam logic [RUN_W-1:0]    TARGET_CONFIRM   = 8'd3;
  localparam logic [RUN_W-1:0]    LIMIT_CONFIRM    = 8'd8;
  localparam logic [RUN_W-1:0]    SEVERE_CONFIRM   = 8'd2;
  localparam logic [GUARD_W-1:0]  GUARD_RELOAD     = 5'd20;

  // Gain steps and limits.
  localparam logic [GAIN_W-1:0]   GAIN_MIN      = 8'd2;
  localparam logic [GAIN_W-1:0]   GAIN_RESET    = 8'd2;
  localparam logic [GAIN_W-1:0]   MAX_GAIN_RESET = 8'd63;
  localparam logic [GAIN_W-1:0]   START_RESET   = 8'd2;
  localparam logic signed [9:0]   STEP_SMALL    = 10'sd1;
  localparam logic signed [9:0]   STEP_BIG      = 10'sd4;

  typedef enum logic [1:0] {
    MODE_ACQUIRE = 2'd0,
    MODE_LOCK    = 2'd1,
    MODE_LIMIT   = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    CLS_STARVED  = 2'd0,
    CLS_TARGET   = 2'd1,
    CLS_HIGH     = 2'd2,
    CLS_OVERLOAD = 2'd3
  } class_e;

  typedef enum logic [1:0] {
    CFG_MAX_GAIN   = 2'd0,
    CFG_START_GAIN = 2'd1,
    CFG_POLAR_MODE = 2'd2
  } cfg_reg_e;

  // One observation window, amplitude in the lowest bits.
  typedef struct packed {
    logic [RATE_W-1:0] wind;
    logic [RATE_W-1:0] orig;
    logic [RATE_W-1:0] clip;
    logic [AMP_W-1:0]  phq;
    logic [AMP_W-1:0]  amp;
  } obs_t;

  typedef struct packed {
    logic [GAIN_W-1:0] max_gain;
    logic [GAIN_W-1:0] start_gain;
    logic              polar;
  } cfg_t;

  // Window history control from the controller.
  typedef struct packed {
    logic push;
    logic clear;
  } win_ctrl_t;

  // Window history status towards the controller.
  typedef struct packed {
    logic valid;
    obs_t med;
  } win_stat_t;

  // One result, gain in the lowest bits.
  typedef struct packed {
    class_e            cls;
    mode_e             mode;
    logic              changed;
    logic [GAIN_W-1:0] gain;
  } result_t;

  localparam int unsigned RES_W = $bits(result_t);

  // Raise to the minimum first, then lower to the maximum.
  function automatic logic [GAIN_W-1:0] limit_gain(input logic signed [9:0] x,
                                                   input logic [GAIN_W-1:0] maxg);
    logic signed [9:0] y;
    y = x;
    if (y < signed'({2'b00, GAIN_MIN})) y = signed'({2'b00, GAIN_MIN});
    if (y > signed'({2'b00, maxg})) y = signed'({2'b00, maxg});
    return y[GAIN_W-1:0];
  endfunction

  function automatic logic [RUN_W-1:0] sat_inc(input logic [RUN_W-1:0] v);
    return (v == {RUN_W{1'b1}}) ? v : RUN_W'(v + 1'b1);
  endfunction

  function automatic class_e classify(input obs_t o);
    class_e c;
    if (o.clip >= 10'd32 || o.amp > 8'd45) begin
      c = CLS_OVERLOAD;
    end else if (o.clip <= 10'd16 && o.amp >= 8'd8 && o.amp <= 8'd34 &&
                 o.phq >= 8'd55 && o.orig <= 10'd350 && o.wind < 10'd300) begin
      c = CLS_TARGET;
    end else if (o.clip > 10'd16 || o.amp > 8'd34) begin
      c = CLS_HIGH;
    end else begin
      c = CLS_STARVED;
    end
    return c;
  endfunction

  // Polar mode lets a high window with otherwise clean figures count as target.
  function automatic logic polar_target(input obs_t o);
    return o.amp <= 8'd45 && o.clip <= 10'd16 && o.phq >= 8'd55 &&
           o.orig <= 10'd350 && o.wind < 10'd300;
  endfunction

  function automatic logic deep_starved(input obs_t o);
    return o.clip <= 10'd8 && o.amp <= 8'd4 && o.phq < 8'd15 && o.orig >= 10'd800;
  endfunction

  function automatic logic lock_hold(input obs_t o, input logic polar);
    logic [AMP_W-1:0] top;
    top = polar ? 8'd45 : 8'd40;
    return o.clip <= 10'd24 && o.amp >= 8'd6 && o.amp <= top &&
           o.phq >= 8'd45 && o.orig <= 10'd500 && o.wind < 10'd320;
  endfunction

  function automatic logic severe_window(input obs_t o);
    return o.clip >= 10'd80 || o.amp > 8'd60;
  endfunction

endpackage

`default_nettype wire

FILE: src/rgc_window.sv
// Observation history shift line with fill count and per-field median network.
`default_nettype none

module rgc_window (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire rgc_pkg::win_ctrl_t  ctrl_i,
  input  wire rgc_pkg::obs_t       obs_i,
  output rgc_pkg::win_stat_t       stat_o
);

  localparam int unsigned D = rgc_pkg::WINDOW_DEPTH;
  localparam int unsigned W = rgc_pkg::RATE_W;

  rgc_pkg::obs_t                   win_q [D];
  rgc_pkg::obs_t                   win_d [D];
  logic [rgc_pkg::FILL_W-1:0]      fill_q, fill_d;
  logic [D-1:0][W-1:0]             amp_v, phq_v, clip_v, orig_v, wind_v;

  // Rank selection: the element with exactly MEDIAN_RANK smaller ones is the median.
  function automatic logic [W-1:0] median_of(input logic [D-1:0][W-1:0] v);
    logic [W-1:0] m;
    int unsigned  rank;
    m = '0;
    for (int i = 0; i < D; i++) begin
      rank = 0;
      for (int j = 0; j < D; j++) begin
        if (v[j] < v[i] || (v[j] == v[i] && j < i)) rank++;
      end
      if (rank == rgc_pkg::MEDIAN_RANK) m = v[i];
    end
    return m;
  endfunction

  // The newest window enters at the bottom; the median is order independent.
  always_comb begin
    win_d[0] = obs_i;
    for (int k = 1; k < D; k++) win_d[k] = win_q[k-1];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      for (int k = 0; k < D; k++) win_q[k] <= win_d[k];
    end
  end

  // Fill count, cleared on any gain change or restart.
  always_comb begin
    fill_d = fill_q;
    if (ctrl_i.push && fill_q < rgc_pkg::FILL_W'(D)) fill_d = rgc_pkg::FILL_W'(fill_q + 1'b1);
    if (ctrl_i.clear) fill_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  // Gather each field over the history including the incoming window.
  always_comb begin
    for (int k = 0; k < D; k++) begin
      amp_v[k]  = W'(win_d[k].amp);
      phq_v[k]  = W'(win_d[k].phq);
      clip_v[k] = win_d[k].clip;
      orig_v[k] = win_d[k].orig;
      wind_v[k] = win_d[k].wind;
    end
  end

  always_comb begin
    stat_o.valid    = (fill_q >= rgc_pkg::FILL_W'(D - 1));
    stat_o.med.amp  = rgc_pkg::AMP_W'(median_of(amp_v));
    stat_o.med.phq  = rgc_pkg::AMP_W'(median_of(phq_v));
    stat_o.med.clip = median_of(clip_v);
    stat_o.med.orig = median_of(orig_v);
    stat_o.med.wind = median_of(wind_v);
  end

endmodule

`default_nettype wire

FILE: src/rgc_ctrl.sv
// Gain state machine: mode, settle, run, lock-loss and guard counters.
`default_nettype none

module rgc_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                step_i,
  input  wire logic                op_i,
  input  wire rgc_pkg::obs_t       obs_i,
  input  wire rgc_pkg::cfg_t       cfg_i,
  input  wire rgc_pkg::win_stat_t  win_i,
  output rgc_pkg::win_ctrl_t       win_o,
  output rgc_pkg::result_t         res_o
);

  logic [rgc_pkg::GAIN_W-1:0]   gain_q, gain_d;
  rgc_pkg::mode_e               mode_q, mode_d;
  logic [rgc_pkg::SETTLE_W-1:0] settle_q, settle_d;
  logic [rgc_pkg::RUN_W-1:0]    run_q, run_d;
  rgc_pkg::class_e              prev_q, prev_d;
  logic [rgc_pkg::RUN_W-1:0]    limit_q, limit_d;
  logic [rgc_pkg::LBAD_W-1:0]   lbad_q, lbad_d;
  logic [rgc_pkg::LBAD_W-1:0]   lbad_inc;
  logic [rgc_pkg::RUN_W-1:0]    severe_q, severe_d;
  logic [rgc_pkg::GUARD_W-1:0]  guard_q, guard_d;

  rgc_pkg::class_e              cls;
  logic                         set_req;
  logic [rgc_pkg::GAIN_W-1:0]   set_val;
  logic                         clear_req;
  logic                         done;
  logic                         hard;
  logic signed [9:0]            gain_s;

  assign gain_s   = signed'({2'b00, gain_q});
  assign lbad_inc = rgc_pkg::LBAD_W'(lbad_q + 1'b1);

  // Filtered class of the current median.
  always_comb begin
    cls = rgc_pkg::classify(win_i.med);
    if (cfg_i.polar && cls == rgc_pkg::CLS_HIGH && rgc_pkg::polar_target(win_i.med)) begin
      cls = rgc_pkg::CLS_TARGET;
    end
  end

  assign hard = rgc_pkg::deep_starved(win_i.med);

  // Next state for one transfer.
  always_comb begin
    gain_d    = gain_q;
    mode_d    = mode_q;
    settle_d  = settle_q;
    run_d     = run_q;
    prev_d    = prev_q;
    limit_d   = limit_q;
    lbad_d    = lbad_q;
    severe_d  = severe_q;
    guard_d   = guard_q;
    set_req   = 1'b0;
    set_val   = gain_q;
    clear_req = 1'b0;
    done      = 1'b0;
    if (step_i) begin
      if (op_i) begin
        // Restart from configuration.
        gain_d    = rgc_pkg::limit_gain(signed'({2'b00, cfg_i.start_gain}), cfg_i.max_gain);
        mode_d    = rgc_pkg::MODE_ACQUIRE;
        settle_d  = rgc_pkg::SETTLE_TICKS;
        run_d     = '0;
        prev_d    = rgc_pkg::CLS_STARVED;
        limit_d   = '0;
        lbad_d    = '0;
        severe_d  = '0;
        guard_d   = '0;
        clear_req = 1'b1;
      end else begin
        if (guard_q != '0) guard_d = rgc_pkg::GUARD_W'(guard_q - 1'b1);
        severe_d = rgc_pkg::severe_window(obs_i) ? rgc_pkg::sat_inc(severe_q) : '0;
        if (severe_d >= rgc_pkg::SEVERE_CONFIRM && settle_q <= rgc_pkg::FAST_SETTLE_MAX) begin
          // Fast path on repeated severe raw windows.
          mode_d  = rgc_pkg::MODE_ACQUIRE;
          set_req = 1'b1;
          set_val = rgc_pkg::limit_gain(gain_s - rgc_pkg::STEP_BIG, cfg_i.max_gain);
        end else if (settle_q != '0) begin
          settle_d = rgc_pkg::SETTLE_W'(settle_q - 1'b1);
        end else if (win_i.valid) begin
          if (prev_q == cls) begin
            run_d = rgc_pkg::sat_inc(run_q);
          end else begin
            prev_d = cls;
            run_d  = rgc_pkg::RUN_W'(1);
          end
          // Leave the limit mode once the signal is no longer starved.
          if (mode_q == rgc_pkg::MODE_LIMIT) begin
            if (cls == rgc_pkg::CLS_STARVED) begin
              done = 1'b1;
            end else begin
              mode_d  = rgc_pkg::MODE_ACQUIRE;
              limit_d = '0;
            end
          end
          // Lock holds until enough consecutive bad windows.
          if (!done && mode_q == rgc_pkg::MODE_LOCK) begin
            if (rgc_pkg::lock_hold(win_i.med, cfg_i.polar)) begin
              lbad_d = '0;
              done   = 1'b1;
            end else if (lbad_inc < rgc_pkg::LOCK_BAD_TICKS) begin
              lbad_d = lbad_inc;
              done   = 1'b1;
            end else begin
              mode_d = rgc_pkg::MODE_ACQUIRE;
              lbad_d = '0;
            end
          end
          // Acquire decisions.
          if (!done) begin
            case (cls)
              rgc_pkg::CLS_TARGET: begin
                if (run_d >= rgc_pkg::TARGET_CONFIRM) begin
                  mode_d = rgc_pkg::MODE_LOCK;
                  lbad_d = '0;
                end
              end
              rgc_pkg::CLS_OVERLOAD: begin
                if (run_d >= rgc_pkg::OVERLOAD_CONFIRM) begin
                  set_req = 1'b1;
                  set_val = rgc_pkg::limit_gain(gain_s - rgc_pkg::STEP_SMALL, cfg_i.max_gain);
                end
              end
              rgc_pkg::CLS_HIGH: begin
                if (run_d >= rgc_pkg::HIGH_CONFIRM) begin
                  set_req = 1'b1;
                  set_val = rgc_pkg::limit_gain(gain_s - rgc_pkg::STEP_SMALL, cfg_i.max_gain);
                end
              end
              default: begin
                if (gain_q >= cfg_i.max_gain) begin
                  limit_d = rgc_pkg::sat_inc(limit_q);
                  if (limit_d >= rgc_pkg::LIMIT_CONFIRM) mode_d = rgc_pkg::MODE_LIMIT;
                end else if (run_d >= (hard ? rgc_pkg::HARD_UP_CONFIRM : rgc_pkg::UP_CONFIRM) &&
                             guard_d == '0) begin
                  set_req = 1'b1;
                  set_val = rgc_pkg::limit_gain(
                      gain_s + (hard ? rgc_pkg::STEP_BIG : rgc_pkg::STEP_SMALL), cfg_i.max_gain);
                end
              end
            endcase
          end
        end
        // A new gain restarts settling and the history.
        if (set_req && set_val != gain_q) begin
          gain_d    = set_val;
          settle_d  = rgc_pkg::SETTLE_TICKS;
          run_d     = '0;
          limit_d   = '0;
          lbad_d    = '0;
          severe_d  = '0;
          clear_req = 1'b1;
          if (set_val < gain_q) guard_d = rgc_pkg::GUARD_RELOAD;
        end
      end
    end
  end

  // Result and history control.
  always_comb begin
    res_o.gain    = gain_d;
    res_o.changed = (gain_d != gain_q);
    res_o.mode    = mode_d;
    res_o.cls     = prev_d;
    win_o.push    = step_i && !op_i;
    win_o.clear   = clear_req;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= rgc_pkg::GAIN_RESET;
      mode_q   <= rgc_pkg::MODE_ACQUIRE;
      settle_q <= rgc_pkg::SETTLE_TICKS;
      run_q    <= '0;
      prev_q   <= rgc_pkg::CLS_STARVED;
      limit_q  <= '0;
      lbad_q   <= '0;
      severe_q <= '0;
      guard_q  <= '0;
    end else begin
      gain_q   <= gain_d;
      mode_q   <= mode_d;
      settle_q <= settle_d;
      run_q    <= run_d;
      prev_q   <= prev_d;
      limit_q  <= limit_d;
      lbad_q   <= lbad_d;
      severe_q <= severe_d;
      guard_q  <= guard_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/rf_gain_controller_top.sv
// Top level of the receiver gain controller: ports, configuration and stage registers.
//
//   channel   direction  handshake                  payload
//   s_axis    in         s_axis_tvalid_i/tready_o   tdata: observation, tuser: op
//   m_axis    out        m_axis_tvalid_o/tready_i   tdata: gain result
//   cfg       in         cfg_valid_i/cfg_ready_o    cfg_index_i, cfg_data_i
//
// An item is registered on entry, decided combinationally and shown in the output
// register; one item per cycle is sustained while the output is not stalled.
// The median network and the state update sit between the two registers.
// Reset gives gain 2, acquire mode and the configuration reset values.
// A stalled output holds its result; the input side still takes one more item.
`default_nettype none

module rf_gain_controller_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // [7:0] amp_median, [15:8] phase_quality, [25:16] clip_rate,
  // [35:26] origin_rate, [45:36] winding_rate, [47:46] zero
  input  wire logic [47:0] s_axis_tdata_i,
  // [0] op
  input  wire logic        s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [7:0] gain_index, [8] gain_changed, [10:9] mode, [12:11] signal_class, [15:13] zero
  output logic [15:0]      m_axis_tdata_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_data_i
);

  rgc_pkg::cfg_t       cfg_q, cfg_d;
  logic                in_valid_q, in_valid_d;
  logic                in_op_q;
  rgc_pkg::obs_t       in_obs_q;
  logic                out_valid_q, out_valid_d;
  rgc_pkg::result_t    out_res_q;
  rgc_pkg::result_t    res;
  rgc_pkg::win_ctrl_t  win_ctrl;
  rgc_pkg::win_stat_t  win_stat;
  logic                advance;
  logic                step;
  logic                s_xfer;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (rgc_pkg::cfg_reg_e'(cfg_index_i))
        rgc_pkg::CFG_MAX_GAIN:   cfg_d.max_gain   = cfg_data_i;
        rgc_pkg::CFG_START_GAIN: cfg_d.start_gain = cfg_data_i;
        rgc_pkg::CFG_POLAR_MODE: cfg_d.polar      = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_gain   <= rgc_pkg::MAX_GAIN_RESET;
      cfg_q.start_gain <= rgc_pkg::START_RESET;
      cfg_q.polar      <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Stage handshake: the decision advances whenever the output register frees up.
  assign advance         = !out_valid_q || m_axis_tready_i;
  assign step            = in_valid_q && advance;
  assign s_axis_tready_o = !in_valid_q || advance;
  assign s_xfer          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_xfer) in_valid_d = 1'b1;
    else if (step) in_valid_d = 1'b0;
    out_valid_d = out_valid_q;
    if (step) out_valid_d = 1'b1;
    else if (m_axis_tready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Input and result payload registers.
  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      in_op_q  <= s_axis_tuser_i;
      in_obs_q <= rgc_pkg::obs_t'(s_axis_tdata_i[rgc_pkg::OBS_W-1:0]);
    end
    if (step) begin
      out_res_q <= res;
    end
  end

  rgc_window u_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (win_ctrl),
    .obs_i  (in_obs_q),
    .stat_o (win_stat)
  );

  rgc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .op_i   (in_op_q),
    .obs_i  (in_obs_q),
    .cfg_i  (cfg_q),
    .win_i  (win_stat),
    .win_o  (win_ctrl),
    .res_o  (res)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(16 - rgc_pkg::RES_W)'(0), out_res_q};

endmodule

`default_nettype wire

FILE: src/rgc_checker.sv
// Port-level checks of the gain controller, bound to the top level.
`default_nettype none

module rgc_port_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [15:0] m_axis_tdata_o
);

  rgc_pkg::result_t            res;
  logic                        m_xfer;
  logic [rgc_pkg::GAIN_W-1:0]  last_gain_q;

  assign res    = rgc_pkg::result_t'(m_axis_tdata_o[rgc_pkg::RES_W-1:0]);
  assign m_xfer = m_axis_tvalid_o && m_axis_tready_i;

  // Gain of the most recent delivered result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_gain_q <= rgc_pkg::GAIN_RESET;
    end else if (m_xfer) begin
      last_gain_q <= res.gain;
    end
  end

  // A stalled result stays in place.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // The input side only backs up behind a stalled output.
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input not ready without output stall");

  // The change flag agrees with the gain of the previous result.
  a_changed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_xfer |-> (res.changed == (res.gain != last_gain_q)))
    else $error("gain change flag inconsistent with gain sequence");

endmodule

bind rf_gain_controller_top rgc_port_checker u_rgc_checker (.*);

`default_nettype wire
